@@ src/pn2d_pkg.sv @@
package pn2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PERM_W    = 8;
  localparam int PERM_SIZE = 1 << PERM_W;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int FADE_W = FRAC_BITS + 1;
  localparam int KW     = FRAC_BITS + 6;
  localparam int GRAD_W = FRAC_BITS + 3;
  localparam int LERP_W = FRAC_BITS + 6;
  localparam int OUT_W  = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef logic [PERM_W-1:0]          perm_t;
  typedef logic [FRAC_BITS-1:0]       frac_t;
  typedef logic [FADE_W-1:0]          fade_t;
  typedef logic signed [KW-1:0]       inner_t;
  typedef logic signed [GRAD_W-1:0]   grad_t;
  typedef logic signed [LERP_W-1:0]   lerp_t;
  typedef logic signed [OUT_W-1:0]    noise_t;

  localparam inner_t FIFTEEN_ONE = inner_t'(15 * ONE);
  localparam inner_t TEN_ONE     = inner_t'(10 * ONE);

  function automatic grad_t grad_sel(input logic [2:0] h, input grad_t gx, input grad_t gy);
    grad_t g;
    case (h)
      3'd0:    g = gx + gy;
      3'd1:    g = gy - gx;
      3'd2:    g = gx - gy;
      3'd3:    g = -gx - gy;
      3'd4:    g = gx;
      3'd5:    g = -gx;
      3'd6:    g = gy;
      default: g = -gy;
    endcase
    return g;
  endfunction

  function automatic noise_t sat_out(input lerp_t r);
    noise_t s;
    if (r > lerp_t'(OUT_MAX)) begin
      s = noise_t'(OUT_MAX);
    end else if (r < lerp_t'(OUT_MIN)) begin
      s = noise_t'(OUT_MIN);
    end else begin
      s = noise_t'(r);
    end
    return s;
  endfunction

endpackage

@@ src/perlin_noise_2d_eval.sv @@
// 2D improved Perlin noise, one point per clock. A transfer with command
// CMD_EVAL takes x_pos/y_pos (signed Q16.16) and presents noise_value (signed
// Q2.16) for that point; a CMD_LOAD transfer writes one entry of the
// 256-entry permutation table and returns nothing. The eight-stage pipeline
// (table lookups, fade multiplies, three lerps) accepts a new transfer every
// cycle; while a result waits with result_ready low the whole pipeline holds
// and item_ready drops. The table is kept in three copies so that no copy
// serves more than two of the six lookups of one point. Load every entry
// before evaluating: entries never written read as arbitrary values.
module perlin_noise_2d_eval import pn2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 command,
  input  logic signed [31:0]   x_pos,
  input  logic signed [31:0]   y_pos,
  input  logic [7:0]           load_index,
  input  logic [7:0]           load_value,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic signed [17:0]   noise_value
);

  logic adv;
  logic acc;
  logic [7:1] vld;

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign acc        = item_valid && item_ready;

  // table copies: a serves the first hash level, b and c the second
  perm_t mem_a [PERM_SIZE];
  perm_t mem_b [PERM_SIZE];
  perm_t mem_c [PERM_SIZE];

  perm_t xc_in, xn_in;
  assign xc_in = x_pos[FRAC_BITS +: PERM_W];
  assign xn_in = xc_in + perm_t'(1);

  // stage 1
  perm_t p0, p1, yc1, yn1;
  frac_t fr1 [2];
  // stage 2
  perm_t h2 [4];
  frac_t fr2 [2];
  frac_t sq2 [2];
  inner_t inr2 [2];
  // stage 3
  grad_t g3 [4];
  frac_t cube3 [2];
  inner_t inr3 [2];
  // stage 4
  grad_t g4 [4];
  fade_t fade4 [2];
  // stage 5
  lerp_t a5 [2];
  lerp_t m5 [2];
  fade_t u5;
  // stage 6
  lerp_t x6 [2];
  fade_t u6;
  // stage 7
  lerp_t x7;
  lerp_t m7;

  perm_t a00, a01, a10, a11;
  assign a00 = p0 + yc1;
  assign a01 = p0 + yn1;
  assign a10 = p1 + yc1;
  assign a11 = p1 + yn1;

  // fade, first step
  frac_t  sq_c  [2];
  inner_t inr_c [2];
  always_comb begin
    logic [2*FRAC_BITS-1:0] tt;
    inner_t tk;
    inner_t k;
    logic signed [KW+FRAC_BITS:0] pk;
    for (int i = 0; i < 2; i++) begin
      tt       = fr1[i] * fr1[i];
      sq_c[i]  = tt[2*FRAC_BITS-1:FRAC_BITS];
      tk       = inner_t'({1'b0, fr1[i]});
      k        = (tk <<< 2) + (tk <<< 1) - FIFTEEN_ONE;
      pk       = $signed({1'b0, fr1[i]}) * k;
      inr_c[i] = inner_t'(pk >>> FRAC_BITS) + TEN_ONE;
    end
  end

  // fade, second step
  frac_t cube_c [2];
  always_comb begin
    logic [2*FRAC_BITS-1:0] tc;
    for (int i = 0; i < 2; i++) begin
      tc        = sq2[i] * fr2[i];
      cube_c[i] = tc[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  // corner gradients; offset fraction t - 1 is the fraction with ones on top
  grad_t g_c [4];
  always_comb begin
    grad_t gx0, gx1, gy0, gy1;
    gx0 = $signed({{(GRAD_W-FRAC_BITS){1'b0}}, fr2[0]});
    gx1 = $signed({{(GRAD_W-FRAC_BITS){1'b1}}, fr2[0]});
    gy0 = $signed({{(GRAD_W-FRAC_BITS){1'b0}}, fr2[1]});
    gy1 = $signed({{(GRAD_W-FRAC_BITS){1'b1}}, fr2[1]});
    g_c[0] = grad_sel(h2[0][2:0], gx0, gy0);
    g_c[1] = grad_sel(h2[1][2:0], gx0, gy1);
    g_c[2] = grad_sel(h2[2][2:0], gx1, gy0);
    g_c[3] = grad_sel(h2[3][2:0], gx1, gy1);
  end

  // fade, last step
  fade_t fade_c [2];
  always_comb begin
    logic signed [KW+FRAC_BITS:0] pf;
    for (int i = 0; i < 2; i++) begin
      pf        = $signed({1'b0, cube3[i]}) * inr3[i];
      fade_c[i] = fade_t'(pf >>> FRAC_BITS);
    end
  end

  // first lerp pair, along y
  lerp_t m_c [2];
  always_comb begin
    lerp_t d;
    logic signed [LERP_W+FADE_W:0] pm;
    for (int i = 0; i < 2; i++) begin
      d      = lerp_t'(g4[2*i+1]) - lerp_t'(g4[2*i]);
      pm     = $signed({1'b0, fade4[1]}) * d;
      m_c[i] = lerp_t'(pm >>> FRAC_BITS);
    end
  end

  // final lerp, along x
  lerp_t m7_c;
  always_comb begin
    lerp_t d;
    logic signed [LERP_W+FADE_W:0] pm;
    d    = x6[1] - x6[0];
    pm   = $signed({1'b0, u6}) * d;
    m7_c = lerp_t'(pm >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (acc && command == CMD_LOAD) begin
      mem_a[load_index] <= load_value;
      mem_b[load_index] <= load_value;
      mem_c[load_index] <= load_value;
    end
    if (adv) begin
      p0    <= mem_a[xc_in];
      p1    <= mem_a[xn_in];
      h2[0] <= mem_b[a00];
      h2[1] <= mem_b[a01];
      h2[2] <= mem_c[a10];
      h2[3] <= mem_c[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yc1    <= y_pos[FRAC_BITS +: PERM_W];
      yn1    <= y_pos[FRAC_BITS +: PERM_W] + perm_t'(1);
      fr1[0] <= x_pos[FRAC_BITS-1:0];
      fr1[1] <= y_pos[FRAC_BITS-1:0];

      fr2  <= fr1;
      sq2  <= sq_c;
      inr2 <= inr_c;

      g3    <= g_c;
      cube3 <= cube_c;
      inr3  <= inr2;

      g4    <= g3;
      fade4 <= fade_c;

      a5[0] <= lerp_t'(g4[0]);
      a5[1] <= lerp_t'(g4[2]);
      m5    <= m_c;
      u5    <= fade4[0];

      x6[0] <= a5[0] + m5[0];
      x6[1] <= a5[1] + m5[1];
      u6    <= u5;

      x7 <= x6[0];
      m7 <= m7_c;

      noise_value <= sat_out(x7 + m7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[6:1], acc && command == CMD_EVAL};
      result_valid <= vld[7];
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    acc && command == CMD_LOAD |=> !vld[1])
    else $error("load entered the result pipeline");

  a_eval_enters: assert property (@(posedge clk) disable iff (rst)
    acc && command == CMD_EVAL |=> vld[1])
    else $error("evaluate transfer lost at pipeline entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(result_valid) && $stable(noise_value))
    else $error("pipeline moved during stall");

endmodule

@@ dv/tb_perlin_noise_2d_eval.sv @@
`timescale 1ns / 1ps

module tb_perlin_noise_2d_eval;
  import pn2d_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    perm_t              idx;
    perm_t              val;
  } xfer_t;

  class noise_scoreboard;
    perm_t  perm [PERM_SIZE];
    noise_t noise_due [$];
    int     errors;

    function new();
      errors = 0;
      foreach (perm[i]) perm[i] = '0;
    endfunction

    // floor(a*b / ONE)
    function longint mul_frac(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FRAC_BITS;
    endfunction

    function longint fade(longint t);
      longint inner;
      longint t3;
      inner = mul_frac(t, 6 * t - 15 * ONE) + 10 * ONE;
      t3 = mul_frac(mul_frac(t, t), t);
      return mul_frac(t3, inner);
    endfunction

    function longint blend(longint a, longint b, longint t);
      return a + mul_frac(t, b - a);
    endfunction

    function longint gradient(perm_t h, longint gx, longint gy);
      longint g;
      case (h[2:0])
        3'd0:    g = gx + gy;
        3'd1:    g = gy - gx;
        3'd2:    g = gx - gy;
        3'd3:    g = -gx - gy;
        3'd4:    g = gx;
        3'd5:    g = -gx;
        3'd6:    g = gy;
        default: g = -gy;
      endcase
      return g;
    endfunction

    function perm_t corner_hash(perm_t cx, perm_t cy);
      perm_t first;
      perm_t slot;
      first = perm[cx];
      slot = first + cy;
      return perm[slot];
    endfunction

    function noise_t noise_at(logic signed [31:0] x, logic signed [31:0] y);
      perm_t  xi, yi, xn, yn;
      longint xf, yf, u, v, x1, x2, r;
      xi = x[23:16];
      yi = y[23:16];
      xf = longint'(x[15:0]);
      yf = longint'(y[15:0]);
      xn = xi + 8'd1;
      yn = yi + 8'd1;
      u = fade(xf);
      v = fade(yf);
      x1 = blend(gradient(corner_hash(xi, yi), xf, yf),
                 gradient(corner_hash(xi, yn), xf, yf - ONE), v);
      x2 = blend(gradient(corner_hash(xn, yi), xf - ONE, yf),
                 gradient(corner_hash(xn, yn), xf - ONE, yf - ONE), v);
      r = blend(x1, x2, u);
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return noise_t'(r);
    endfunction

    function void record_transfer(xfer_t t);
      if (t.cmd == CMD_LOAD) begin
        perm[t.idx] = t.val;
      end else begin
        noise_due.push_back(noise_at(t.x, t.y));
      end
    endfunction

    function void check_noise(noise_t got);
      noise_t want;
      if (noise_due.size() == 0) begin
        $error("noise_value: expected none, got %0d", got);
        errors++;
      end else begin
        want = noise_due.pop_front();
        if (got !== want) begin
          $error("noise_value: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return noise_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic               command;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic [7:0]         load_index;
  logic [7:0]         load_value;
  logic               result_valid;
  logic               result_ready;
  logic signed [17:0] noise_value;

  noise_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;

  perlin_noise_2d_eval u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .load_index   (load_index),
    .load_value   (load_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .noise_value  (noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    result_ready <= 1'b0;
    forever begin
      @(negedge clk);
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_noise(noise_value);
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(xfer_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    item_valid <= 1'b1;
    command    <= t.cmd;
    x_pos      <= t.x;
    y_pos      <= t.y;
    load_index <= t.idx;
    load_value <= t.val;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.record_transfer(t);
    @(negedge clk);
  endtask

  task automatic send_load(perm_t idx, perm_t val);
    xfer_t t;
    t.cmd = CMD_LOAD;
    t.x   = $urandom;
    t.y   = $urandom;
    t.idx = idx;
    t.val = val;
    send(t);
  endtask

  task automatic send_eval(logic signed [31:0] x, logic signed [31:0] y);
    xfer_t t;
    t.cmd = CMD_EVAL;
    t.x   = x;
    t.y   = y;
    t.idx = perm_t'($urandom_range(255));
    t.val = perm_t'($urandom_range(255));
    send(t);
  endtask

  task automatic fill_shuffled();
    perm_t sh [PERM_SIZE];
    perm_t tmp;
    int    j;
    foreach (sh[i]) sh[i] = perm_t'(i);
    for (int i = PERM_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = sh[i];
      sh[i] = sh[j];
      sh[j] = tmp;
    end
    foreach (sh[i]) send_load(perm_t'(i), sh[i]);
  endtask

  function automatic logic signed [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0:       return r;
      1:       return {r[31:16], 16'h0000};
      2:       return {r[31:16], 16'hFFFF};
      3:       return {r[31:24], 8'hFF, r[15:0]};
      default: return {{14{r[17]}}, r[17:0]};
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        send_load(perm_t'($urandom_range(255)), perm_t'($urandom_range(255)));
      end else begin
        send_eval(rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    command        <= CMD_EVAL;
    x_pos          <= '0;
    y_pos          <= '0;
    load_index     <= '0;
    load_value     <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    fill_shuffled();

    send_eval(32'sh0000_0000, 32'sh0000_0000);
    send_eval(32'sh8000_0000, 32'sh8000_0000);
    send_eval(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_eval(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_eval(32'sh00FF_FFFF, 32'sh00FF_0000);
    send_eval(32'shFFFF_FFFF, 32'shFFFF_FFFF);
    send_eval(32'sh0000_8000, 32'sh0000_8000);
    send_eval(32'shFFFE_8000, 32'sh0001_0000);
    send_eval(32'sh00FF_0000, 32'shFFFF_0001);
    send_eval(32'sh0000_FFFF, 32'sh0000_0001);
    send_load(8'h00, 8'hFF);
    send_load(8'hFF, 8'h00);
    send_eval(32'sh0000_0000, 32'sh0000_0000);
    send_eval(32'sh00FF_4000, 32'sh00FF_C000);
    send_eval(32'sh0000_FFFF, 32'sh00FF_FFFF);
    send_load(8'h80, 8'h7F);
    send_eval(32'sh0080_2000, 32'shFF7F_E000);
    send_eval(32'sh1234_5678, 32'shEDCB_A987);

    random_items(155);
    send_idle_pct = 59;
    random_items(155);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    random_items(155);
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    random_items(155);

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/pn2d_pkg.sv
src/perlin_noise_2d_eval.sv
dv/tb_perlin_noise_2d_eval.sv
